// ----- src/normalized_cross_correlation_lags_assert.svh -----
// Assertion macros used by the compute engine of the normalized cross-correlation RTL.
`ifndef NORMALIZED_CROSS_CORRELATION_LAGS_ASSERT_SVH
`define NORMALIZED_CROSS_CORRELATION_LAGS_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define NCCL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define NCCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/nccl_pkg.sv -----
// Package with the shared types and constants of the cross-correlation block.
package nccl_pkg;

  localparam int WINDOW_MAX_DEF  = 32;
  localparam int LAG_MAX_DEF     = 63;
  localparam int STORE_DEPTH_DEF = 128;
  localparam int QUEUE_DEPTH     = 4;

  localparam int SAMPLE_W = 16;
  localparam int CORR_W   = 16;
  localparam int CFG_W    = 6;
  localparam int LAG_W    = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 6'd18;
  localparam logic [CFG_W-1:0] MIN_LAG_RST       = 6'd4;
  localparam logic [CFG_W-1:0] MAX_LAG_RST       = 6'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_MIN_LAG       = 2'd1,
    REG_MAX_LAG       = 2'd2
  } cfg_reg_t;

  // One word passed from the front end to the compute engine.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       keep;
    logic                       frame_end;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] window_length;
    logic [CFG_W-1:0] min_lag;
    logic [CFG_W-1:0] max_lag;
  } cfg_t;

  typedef struct packed {
    logic [LAG_W-1:0]         lag;
    logic signed [CORR_W-1:0] correlation;
    logic                     zero_energy;
    logic                     last;
  } res_t;

endpackage

// ----- src/nccl_in_if.sv -----
// Input channel: one sample word with its frame end mark.
interface nccl_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [nccl_pkg::SAMPLE_W-1:0] sample;
  logic                                frame_end;
  modport source(output valid, sample, frame_end, input ready);
  modport sink(input valid, sample, frame_end, output ready);
endinterface

// ----- src/nccl_out_if.sv -----
// Result channel: one correlation word per lag.
interface nccl_out_if;
  logic                              valid;
  logic                              ready;
  logic [nccl_pkg::LAG_W-1:0]         lag;
  logic signed [nccl_pkg::CORR_W-1:0] correlation;
  logic                              zero_energy;
  logic                              last;
  modport source(output valid, lag, correlation, zero_energy, last, input ready);
  modport sink(input valid, lag, correlation, zero_energy, last, output ready);
endinterface

// ----- src/nccl_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface nccl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nccl_pkg::CFG_IDX_W-1:0]    index;
  logic [nccl_pkg::CFG_W-1:0]        data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- src/nccl_front.sv -----
// Front end: accepts sample words, counts the frame and marks dropped samples.
module nccl_front #(
  parameter int STORE_DEPTH = nccl_pkg::STORE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  nccl_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           q_push,
  output nccl_pkg::cmd_t q_cmd
);
  import nccl_pkg::*;

  localparam int FILL_W = $clog2(STORE_DEPTH + 1);

  logic [FILL_W-1:0] fill_r;
  logic              keep;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  // Once the store is full, further samples of the frame are dropped.
  assign keep        = fill_r < FILL_W'(STORE_DEPTH);

  assign q_cmd.sample    = in_ch.sample;
  assign q_cmd.keep      = keep;
  assign q_cmd.frame_end = in_ch.frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (q_push) begin
      if (in_ch.frame_end) begin
        fill_r <= '0;
      end else if (keep) begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

endmodule

// ----- src/nccl_fifo.sv -----
// Short word queue between the front end and the compute engine.
module nccl_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nccl_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output nccl_pkg::cmd_t dout,
  output logic           not_empty
);
  import nccl_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign dout      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/nccl_back.sv -----
// Compute engine: sample store, correlation sums, normalization and result register.
`include "normalized_cross_correlation_lags_assert.svh"
module nccl_back #(
  parameter int WINDOW_MAX  = nccl_pkg::WINDOW_MAX_DEF,
  parameter int LAG_MAX     = nccl_pkg::LAG_MAX_DEF,
  parameter int STORE_DEPTH = nccl_pkg::STORE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  nccl_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  nccl_pkg::cfg_t cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output nccl_pkg::res_t out_res
);
  import nccl_pkg::*;

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int J_W    = $clog2(WINDOW_MAX + 1);
  localparam int K_W    = $clog2(LAG_MAX + 1);
  localparam int S_W    = ((J_W > K_W) ? J_W : K_W) + 1;
  localparam int A_W    = (S_W > FILL_W) ? S_W : FILL_W;
  localparam int E_W    = 31 + J_W;
  localparam int P_W    = E_W + 1;
  localparam int X_W    = 2 * E_W + 36;
  localparam int MC_W   = $clog2(E_W + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_MUL, S_SRCH_A, S_SRCH_B, S_EMIT
  } state_t;

  state_t state_r;

  logic signed [SAMPLE_W-1:0] mem [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_a_r, rd_b_r;

  logic [FILL_W-1:0] wp_r, fill_r;
  logic [J_W-1:0]    w_r, j_r;
  logic [K_W-1:0]    k_r, k1_r;
  logic              rd_v_r, pv_r, ok_a_r, ok_b_r;
  logic signed [31:0]    prod_p_r, prod_a_r, prod_b_r;
  logic signed [P_W-1:0] p_acc_r;
  logic [E_W-1:0]        e0_acc_r, ek_acc_r;
  logic [2*E_W-1:0]      me_a_r, me_acc_r, mt_a_r, mt_acc_r;
  logic [E_W-1:0]        me_b_r, mt_b_r;
  logic [MC_W-1:0]       mc_r;
  logic signed [X_W-1:0] eq_r, g_r, es_r, tmp_r;
  logic [3:0]            bit_r;
  logic [CORR_W-1:0]     m_r;
  logic                  p_neg_r, zero_r;
  logic                  out_valid_r;
  res_t                  out_res_r;

  logic [J_W-1:0]        w_new;
  logic [K_W-1:0]        k0_new, k1_new;
  logic [A_W-1:0]        addr_a, addr_b;
  logic signed [SAMPLE_W-1:0] sa, sb;
  logic [P_W-1:0]        p_abs;
  logic [E_W-1:0]        ap;
  logic signed [X_W-1:0] e_ext, t_ext, cand, g_sum;
  logic                  take, mac_done, out_free, wr_en;
  logic [CORR_W-1:0]     corr;

  // Register values above the supported range are clamped.
  assign w_new  = (32'(cfg.window_length) > 32'(WINDOW_MAX)) ? J_W'(WINDOW_MAX)
                                                            : J_W'(cfg.window_length);
  assign k0_new = (32'(cfg.min_lag) > 32'(LAG_MAX)) ? K_W'(LAG_MAX) : K_W'(cfg.min_lag);
  assign k1_new = (32'(cfg.max_lag) > 32'(LAG_MAX)) ? K_W'(LAG_MAX) : K_W'(cfg.max_lag);

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;
  assign wr_en   = cmd_pop && cmd.keep;

  assign addr_a = A_W'(j_r);
  assign addr_b = A_W'(k_r) + A_W'(j_r);

  // Positions past the end of the frame read as zero.
  assign sa = ok_a_r ? rd_a_r : '0;
  assign sb = ok_b_r ? rd_b_r : '0;

  assign mac_done = (state_r == S_MAC) && (j_r == w_r) && !rd_v_r && !pv_r;

  assign p_abs = p_acc_r[P_W-1] ? P_W'(-p_acc_r) : P_W'(p_acc_r);
  assign ap    = E_W'(p_abs);

  // Square-root search: e*q*q is kept in eq_r, e*q shifted in g_r, e shifted in es_r.
  assign e_ext = $signed(X_W'(me_acc_r));
  assign t_ext = $signed(X_W'({mt_acc_r, 32'b0}));
  assign cand  = tmp_r + g_r;
  assign take  = cand <= t_ext;
  assign g_sum = take ? g_r + (es_r <<< 1) : g_r;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (zero_r) begin
      corr = '0;
    end else if (p_neg_r) begin
      corr = CORR_W'(-m_r);
    end else if (m_r[CORR_W-1]) begin
      corr = {1'b0, {(CORR_W-1){1'b1}}};
    end else begin
      corr = m_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r[AW-1:0]] <= cmd.sample;
    end
    rd_a_r <= mem[addr_a[AW-1:0]];
    rd_b_r <= mem[addr_b[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rd_v_r      <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r   <= (state_r == S_MAC) && (j_r != w_r);
      pv_r     <= rd_v_r;
      ok_a_r   <= addr_a < A_W'(fill_r);
      ok_b_r   <= addr_b < A_W'(fill_r);
      prod_p_r <= 32'(sa) * 32'(sb);
      prod_a_r <= 32'(sa) * 32'(sa);
      prod_b_r <= 32'(sb) * 32'(sb);
      if (pv_r) begin
        p_acc_r  <= p_acc_r + P_W'(prod_p_r);
        e0_acc_r <= e0_acc_r + E_W'($unsigned(prod_a_r));
        ek_acc_r <= ek_acc_r + E_W'($unsigned(prod_b_r));
      end
      // A word that is taken leaves the register unless a new one is loaded.
      if (out_ready && !((state_r == S_EMIT) && out_free)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            if (cmd.frame_end) begin
              fill_r   <= wp_r + FILL_W'(cmd.keep);
              wp_r     <= '0;
              w_r      <= w_new;
              k_r      <= k0_new;
              k1_r     <= k1_new;
              j_r      <= '0;
              p_acc_r  <= '0;
              e0_acc_r <= '0;
              ek_acc_r <= '0;
              if (k0_new <= k1_new) begin
                state_r <= S_MAC;
              end
            end else begin
              wp_r <= wp_r + FILL_W'(cmd.keep);
            end
          end
        end
        S_MAC: begin
          if (j_r != w_r) begin
            j_r <= j_r + J_W'(1);
          end
          if (mac_done) begin
            p_neg_r <= p_acc_r[P_W-1];
            if (e0_acc_r == '0 || ek_acc_r == '0) begin
              zero_r  <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              zero_r   <= 1'b0;
              me_a_r   <= (2*E_W)'(e0_acc_r);
              me_b_r   <= ek_acc_r;
              me_acc_r <= '0;
              mt_a_r   <= (2*E_W)'(ap);
              mt_b_r   <= ap;
              mt_acc_r <= '0;
              mc_r     <= MC_W'(E_W);
              state_r  <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mc_r != '0) begin
            // One multiplier bit per cycle for both products.
            if (me_b_r[0]) me_acc_r <= me_acc_r + me_a_r;
            if (mt_b_r[0]) mt_acc_r <= mt_acc_r + mt_a_r;
            me_a_r <= me_a_r << 1;
            mt_a_r <= mt_a_r << 1;
            me_b_r <= me_b_r >> 1;
            mt_b_r <= mt_b_r >> 1;
            mc_r   <= mc_r - MC_W'(1);
          end else begin
            eq_r    <= e_ext;
            g_r     <= -(e_ext <<< 17);
            es_r    <= e_ext <<< 32;
            bit_r   <= 4'd15;
            m_r     <= '0;
            state_r <= S_SRCH_A;
          end
        end
        S_SRCH_A: begin
          tmp_r   <= eq_r + es_r;
          state_r <= S_SRCH_B;
        end
        S_SRCH_B: begin
          if (take) begin
            eq_r       <= cand;
            m_r[bit_r] <= 1'b1;
          end
          g_r   <= g_sum >>> 1;
          es_r  <= es_r >>> 2;
          bit_r <= bit_r - 4'd1;
          state_r <= (bit_r == 4'd0) ? S_EMIT : S_SRCH_A;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_res_r.lag         <= LAG_W'(k_r);
            out_res_r.correlation <= corr;
            out_res_r.zero_energy <= zero_r;
            out_res_r.last        <= k_r == k1_r;
            if (k_r == k1_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r      <= k_r + K_W'(1);
              j_r      <= '0;
              p_acc_r  <= '0;
              e0_acc_r <= '0;
              ek_acc_r <= '0;
              state_r  <= S_MAC;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `NCCL_ASSERT_IMP(a_wp_bound, 1'b1, wp_r <= FILL_W'(STORE_DEPTH), "write pointer past store")
  `NCCL_ASSERT_NEXT(a_frame_starts, cmd_pop && cmd.frame_end && (k0_new <= k1_new),
                    state_r == S_MAC, "frame end did not start the lag loop")
  `NCCL_ASSERT_IMP(a_zero_corr, out_valid_r && out_res_r.zero_energy,
                   out_res_r.correlation == '0, "zero energy with nonzero value")
  `NCCL_ASSERT_IMP(a_mag_bound, (state_r == S_EMIT) && !zero_r, m_r <= 16'd32768,
                   "magnitude above full scale")

endmodule

// ----- src/normalized_cross_correlation_lags.sv -----
// Top level of the normalized cross-correlation block over a range of lags.
//
// Sample words are stored in arrival order until a word with frame_end set; then one
// result word is produced for every lag from min_lag to max_lag: the window sum of
// s[j]*s[j+k] divided by the square root of the reference and lagged window energies,
// as a rounded Q1.15 value saturated to 32767. A zero energy gives 0 with zero_energy
// set, and min_lag above max_lag gives no result word. Sample words are taken one per
// cycle while the four-word queue in front of the compute engine has room, so a frame
// streams in at full rate and waits only behind the previous frame's computation.
// After a frame end, each lag goes through the multiply-accumulate pass over the two
// store read ports, the bit-serial multiplier that forms the energy product and the
// squared sum, the rounding square-root search, and the load of the result register.
// A lag with zero energy skips the multiplier and the search. A result word that is
// not taken holds the engine before the next lag is loaded. The result register lets
// the next lag start while a word waits to be taken. The sample store has no reset and
// needs no clearing pass; positions beyond the samples of the current frame read as
// zero. The user must write configuration through the cfg channel, which is always
// ready, only while the block is idle; the block itself does not enforce this.
module normalized_cross_correlation_lags #(
  parameter int WINDOW_MAX  = nccl_pkg::WINDOW_MAX_DEF,
  parameter int LAG_MAX     = nccl_pkg::LAG_MAX_DEF,
  parameter int STORE_DEPTH = nccl_pkg::STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nccl_in_if.sink    in_ch,
  nccl_out_if.source out_ch,
  nccl_cfg_if.sink   cfg_ch
);
  import nccl_pkg::*;

  logic [CFG_W-1:0] window_length_r;
  logic [CFG_W-1:0] min_lag_r;
  logic [CFG_W-1:0] max_lag_r;
  cfg_t             cfg;

  cmd_t q_in, q_out;
  logic q_push, q_full, q_pop, q_not_empty;
  logic out_valid;
  res_t out_res;

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_LENGTH_RST;
      min_lag_r       <= MIN_LAG_RST;
      max_lag_r       <= MAX_LAG_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_WINDOW_LENGTH: window_length_r <= cfg_ch.data;
        REG_MIN_LAG:       min_lag_r       <= cfg_ch.data;
        REG_MAX_LAG:       max_lag_r       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg.window_length = window_length_r;
  assign cfg.min_lag       = min_lag_r;
  assign cfg.max_lag       = max_lag_r;

  nccl_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  nccl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_out),
    .not_empty (q_not_empty)
  );

  nccl_back #(
    .WINDOW_MAX (WINDOW_MAX),
    .LAG_MAX    (LAG_MAX),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_out),
    .cmd_valid (q_not_empty),
    .cmd_pop   (q_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.lag         = out_res.lag;
  assign out_ch.correlation = out_res.correlation;
  assign out_ch.zero_energy = out_res.zero_energy;
  assign out_ch.last        = out_res.last;

endmodule
